@@ hw/rtl/pira_pkg.sv @@
// Shared types and codes for the positional insert/remove array.
package pira_pkg;

    // Operation codes carried on the action field
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_UNUSED   = 2'd3
    } status_t;

    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned POSITION_W = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 5;

endpackage

@@ hw/rtl/positional_insert_remove_array.sv @@
// Positional insert/remove array: packed word store with shift-based insert, remove and dump.
// Steps: insert inside the array reads and writes each moved element (S_SRD, S_SWR), then
//   puts the word (S_PUT); insert past the end zero-fills each gap entry (S_FILL), then puts
//   the word; remove reads and writes each moved element; a dump reads each item (S_DRD)
//   and gives it (S_EMIT). Every other item goes straight to S_EMIT. Throughput: one item at
//   a time; in_ready is high only while idle.
// Reset: count and control clear at once; memory contents stay undefined until written.
module positional_insert_remove_array #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [pira_pkg::ACTION_W-1:0]          action,
    input  logic [pira_pkg::POSITION_W-1:0]        position,
    input  logic signed [pira_pkg::WORD_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [pira_pkg::STATUS_W-1:0]          status,
    output logic [pira_pkg::COUNT_W-1:0]           count,
    output logic signed [pira_pkg::WORD_W-1:0]     element,
    output logic                                   last
);
    import pira_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = POSITION_W + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SRD  = 7'b0000010,
        S_SWR  = 7'b0000100,
        S_FILL = 7'b0001000,
        S_PUT  = 7'b0010000,
        S_DRD  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [WORD_W-1:0]   val_reg, val_next;
    logic                rem_reg, rem_next;
    logic                dump_reg, dump_next;
    status_t             res_reg, res_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0]   element_reg, element_next;
    logic                last_reg, last_next;

    // Word store with its write port and its registered read port
    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                mem_re, mem_we;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [WORD_W-1:0]   wr_data;

    // Decode of the incoming item
    logic [EW-1:0]       pos_ext, cnt_ext, ins_cnt;
    logic                beyond, ins_ovf, out_free, dump_last;
    action_t             act;

    assign act      = action_t'(action);
    assign pos_ext  = {1'b0, position};
    assign cnt_ext  = EW'(cnt_reg);
    assign beyond   = (pos_ext >= cnt_ext);
    assign ins_cnt  = beyond ? (pos_ext + EW'(1)) : (cnt_ext + EW'(1));
    assign ins_ovf  = (ins_cnt > EW'(DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign dump_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    // Shift source: one below for insert, one above for remove, direct for dump
    always_comb
    begin
        if (dump_reg)
            rd_addr = idx_reg;
        else if (rem_reg)
            rd_addr = idx_reg + AW'(1);
        else
            rd_addr = idx_reg - AW'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rem_next       = rem_reg;
        dump_next      = dump_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        count_next     = count_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next  = AW'(position);
                    val_next  = value;
                    rem_next  = 1'b0;
                    dump_next = 1'b0;
                    res_next  = ST_DONE;
                    state_next = S_EMIT;
                    unique case (act)
                        ACT_INSERT:
                        begin
                            if (ins_ovf)
                                res_next = ST_OVERFLOW;
                            else
                            begin
                                cnt_next = CW'(ins_cnt);
                                idx_next = AW'(cnt_reg);
                                if (!beyond)
                                    state_next = S_SRD;
                                else if (pos_ext == cnt_ext)
                                    state_next = S_PUT;
                                else
                                    state_next = S_FILL;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (beyond)
                                res_next = ST_IGNORED;
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                                idx_next = AW'(position);
                                rem_next = 1'b1;
                                if (pos_ext + EW'(1) != cnt_ext)
                                    state_next = S_SRD;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (cnt_reg == '0)
                                res_next = ST_IGNORED;
                            else
                            begin
                                dump_next  = 1'b1;
                                idx_next   = '0;
                                state_next = S_DRD;
                            end
                        end
                        default:
                            res_next = ST_IGNORED;
                    endcase
                end
            end
            S_SRD:
            begin
                mem_re     = 1'b1;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                // Move one word, then step toward the insert position, or for remove toward the new end
                mem_we  = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if (rem_reg)
                begin
                    idx_next = idx_reg + AW'(1);
                    if ((CW'(idx_reg) + CW'(2)) == (cnt_reg + CW'(1)))
                        state_next = S_EMIT;
                    else
                        state_next = S_SRD;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                    if ((idx_reg - AW'(1)) == pos_reg)
                        state_next = S_PUT;
                    else
                        state_next = S_SRD;
                end
            end
            S_FILL:
            begin
                // Zero the gap between the old end and the new position
                mem_we   = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = '0;
                idx_next = idx_reg + AW'(1);
                if ((idx_reg + AW'(1)) == pos_reg)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                state_next = S_EMIT;
            end
            S_DRD:
            begin
                mem_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    count_next     = COUNT_W'(cnt_reg);
                    element_next   = dump_reg ? rd_data_reg : '0;
                    last_next      = !dump_reg || dump_last;
                    if (dump_reg && !dump_last)
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_DRD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        rem_reg     <= rem_next;
        dump_reg    <= dump_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        count_reg   <= count_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
    end

    // Memory read port, registered
    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign element   = element_reg;
    assign last      = last_reg;

endmodule

@@ hw/rtl/pira_checker.sv @@
// Port-level checker for the positional insert/remove array, with its bind.
module pira_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [pira_pkg::STATUS_W-1:0]          status,
    input  logic [pira_pkg::COUNT_W-1:0]           count,
    input  logic signed [pira_pkg::WORD_W-1:0]     element,
    input  logic                                   last
);
    import pira_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
            && $stable(element) && $stable(last))
        else $error("stalled result changed");

    // Drop ready in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted back to back");

    // A result other than a done carries no element and ends its item
    a_not_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> (element == '0) && last)
        else $error("ignored or overflow result malformed");

    // Status never carries the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE) || (status == ST_IGNORED)
            || (status == ST_OVERFLOW))
        else $error("bad status code");

    // Count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= DEPTH))
        else $error("count above depth");

endmodule

bind positional_insert_remove_array pira_checker #(.DEPTH(DEPTH)) u_pira_checker (.*);
